FILE: rtl/core/nco_cfs_pkg.sv
// Shared types, constants and the sine table generator for the NCO frequency shifter.
`timescale 1ns / 1ps
`default_nettype none

package nco_cfs_pkg;

  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int PHASE_BITS_DEF      = 32;
  localparam int TABLE_ADDR_BITS_DEF = 10;

  localparam int STEP_BITS      = 32;
  localparam int CFG_INDEX_BITS = 8;

  localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;

  // Taylor series denominators (2n)(2n+1) for n = 1 to 8.
  localparam logic [63:0] TAYLOR_DIV [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PHASE_STEP      = CFG_INDEX_BITS'(0),
    REG_CONTINUOUS_MODE = CFG_INDEX_BITS'(1)
  } cfg_reg_t;

  typedef struct packed {
    logic adv_a;
    logic adv_b;
    logic adv_c;
  } pipe_ctl_t;

  // Entry k of a quarter-wave sine table, evaluated at elaboration from a
  // Q30 Taylor series and scaled to the full positive sample range.
  function automatic logic [63:0] sine_entry(input int k, input int sample_bits,
                                             input int addr_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    longint      amp;
    longint      v;
    x    = (HALFPI_Q30 * 64'(2 * k + 1)) >> (addr_bits + 1);
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      term = (term * x2) >> 30;
      term = term / TAYLOR_DIV[3'(n - 1)];
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    amp = (longint'(1) <<< (sample_bits - 1)) - 1;
    v   = (sum * amp + (longint'(1) <<< 29)) >>> 30;
    if (v > amp) begin
      v = amp;
    end
    return 64'(v);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/nco_cfs_phase.sv
// Configuration registers and the phase accumulator of the NCO.
`timescale 1ns / 1ps
`default_nettype none

module nco_cfs_phase #(
  parameter int PHASE_BITS      = nco_cfs_pkg::PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = nco_cfs_pkg::TABLE_ADDR_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_write,
  input  wire logic [nco_cfs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [nco_cfs_pkg::STEP_BITS-1:0]      cfg_data,
  input  wire logic                                   accept,
  input  wire logic                                   last,
  output logic      [TABLE_ADDR_BITS+1:0]             table_idx
);
  import nco_cfs_pkg::*;

  logic signed [STEP_BITS-1:0]  phase_step;
  logic                         continuous_mode;
  logic        [PHASE_BITS-1:0] phase;
  logic        [PHASE_BITS-1:0] phase_next;
  logic        [PHASE_BITS-1:0] step_ext;

  generate
    if (PHASE_BITS >= STEP_BITS) begin : g_step_wide
      assign step_ext = PHASE_BITS'(phase_step) << (PHASE_BITS - STEP_BITS);
    end else begin : g_step_narrow
      assign step_ext = phase_step[STEP_BITS-1 -: PHASE_BITS];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step      <= '0;
      continuous_mode <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PHASE_STEP:      phase_step      <= cfg_data;
        REG_CONTINUOUS_MODE: continuous_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next = phase + step_ext;
    if (last && !continuous_mode) begin
      phase_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  assign table_idx = phase[PHASE_BITS-1 -: TABLE_ADDR_BITS+2];

endmodule

`default_nettype wire

FILE: rtl/core/nco_cfs_sine_rom.sv
// Quarter-wave sine ROM with registered reads of the sine and cosine magnitudes.
`timescale 1ns / 1ps
`default_nettype none

module nco_cfs_sine_rom #(
  parameter int SAMPLE_BITS     = nco_cfs_pkg::SAMPLE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = nco_cfs_pkg::TABLE_ADDR_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire nco_cfs_pkg::pipe_ctl_t       ctl,
  input  wire logic [TABLE_ADDR_BITS+1:0]   table_idx,
  output logic      [SAMPLE_BITS-2:0]       s_mag,
  output logic      [SAMPLE_BITS-2:0]       c_mag,
  output logic                              s_neg,
  output logic                              c_neg
);
  import nco_cfs_pkg::*;

  localparam int TBL_LEN = 1 << TABLE_ADDR_BITS;

  logic [SAMPLE_BITS-2:0]     rom [TBL_LEN];
  logic [1:0]                 quad;
  logic [TABLE_ADDR_BITS-1:0] addr;
  logic [TABLE_ADDR_BITS-1:0] addr_rev;
  logic [TABLE_ADDR_BITS-1:0] addr_s;
  logic [TABLE_ADDR_BITS-1:0] addr_c;

  generate
    for (genvar k = 0; k < TBL_LEN; k++) begin : g_rom
      assign rom[k] = (SAMPLE_BITS - 1)'(sine_entry(k, SAMPLE_BITS, TABLE_ADDR_BITS));
    end
  endgenerate

  assign quad     = table_idx[TABLE_ADDR_BITS+1:TABLE_ADDR_BITS];
  assign addr     = table_idx[TABLE_ADDR_BITS-1:0];
  assign addr_rev = ~addr;

  // Odd quadrants read the table mirrored for sine and straight for cosine.
  assign addr_s = quad[0] ? addr_rev : addr;
  assign addr_c = quad[0] ? addr : addr_rev;

  always_ff @(posedge clk) begin
    if (ctl.adv_a) begin
      s_mag <= rom[addr_s];
      c_mag <= rom[addr_c];
      s_neg <= quad[1];
      c_neg <= quad[1] ^ quad[0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/nco_cfs_mixer.sv
// Complex multiplier with rounding and saturation back to the sample width.
`timescale 1ns / 1ps
`default_nettype none

module nco_cfs_mixer #(
  parameter int SAMPLE_BITS = nco_cfs_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire nco_cfs_pkg::pipe_ctl_t        ctl,
  input  wire logic signed [SAMPLE_BITS-1:0] smp_i,
  input  wire logic signed [SAMPLE_BITS-1:0] smp_q,
  input  wire logic        [SAMPLE_BITS-2:0] s_mag,
  input  wire logic        [SAMPLE_BITS-2:0] c_mag,
  input  wire logic                          s_neg,
  input  wire logic                          c_neg,
  output logic signed      [SAMPLE_BITS-1:0] out_i,
  output logic signed      [SAMPLE_BITS-1:0] out_q
);
  import nco_cfs_pkg::*;

  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + 1;
  localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1) << (SAMPLE_BITS - 2);
  localparam logic signed [ACC_W-1:0] SMAX = (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SMIN = -(ACC_W'(1) << (SAMPLE_BITS - 1));

  logic signed [SAMPLE_BITS-1:0] cos_v;
  logic signed [SAMPLE_BITS-1:0] sin_v;
  logic signed [PROD_W-1:0]      p_ic;
  logic signed [PROD_W-1:0]      p_qs;
  logic signed [PROD_W-1:0]      p_is;
  logic signed [PROD_W-1:0]      p_qc;
  logic signed [ACC_W-1:0]       acc_i;
  logic signed [ACC_W-1:0]       acc_q;
  logic signed [ACC_W-1:0]       shr_i;
  logic signed [ACC_W-1:0]       shr_q;
  logic signed [SAMPLE_BITS-1:0] out_i_next;
  logic signed [SAMPLE_BITS-1:0] out_q_next;

  always_comb begin
    cos_v = signed'({1'b0, c_mag});
    sin_v = signed'({1'b0, s_mag});
    if (c_neg) begin
      cos_v = -cos_v;
    end
    if (s_neg) begin
      sin_v = -sin_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv_b) begin
      p_ic <= smp_i * cos_v;
      p_qs <= smp_q * sin_v;
      p_is <= smp_i * sin_v;
      p_qc <= smp_q * cos_v;
    end
  end

  // Rounding adds half an LSB and floors, so ties go toward plus infinity.
  always_comb begin
    acc_i = ACC_W'(p_ic) - ACC_W'(p_qs) + RND;
    acc_q = ACC_W'(p_is) + ACC_W'(p_qc) + RND;
    shr_i = acc_i >>> (SAMPLE_BITS - 1);
    shr_q = acc_q >>> (SAMPLE_BITS - 1);
    if (shr_i > SMAX) begin
      out_i_next = SMAX[SAMPLE_BITS-1:0];
    end else if (shr_i < SMIN) begin
      out_i_next = SMIN[SAMPLE_BITS-1:0];
    end else begin
      out_i_next = shr_i[SAMPLE_BITS-1:0];
    end
    if (shr_q > SMAX) begin
      out_q_next = SMAX[SAMPLE_BITS-1:0];
    end else if (shr_q < SMIN) begin
      out_q_next = SMIN[SAMPLE_BITS-1:0];
    end else begin
      out_q_next = shr_q[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv_c) begin
      out_i <= out_i_next;
      out_q <= out_q_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/nco_complex_frequency_shifter.sv
// Top level of the NCO complex frequency shifter with pipeline flow control.
// Three register stages; the edge that accepts an input word loads it into the
// first stage, and it then moves on through the product and output registers.
// Throughput: one word per clock while out_stall is low; the stages are the
// registered sine ROM read, four products, round-and-saturate output register.
// Reset clears the phase to zero, the phase step to zero, selects continuous
// mode and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module nco_complex_frequency_shifter #(
  parameter int SAMPLE_BITS     = nco_cfs_pkg::SAMPLE_BITS_DEF,
  parameter int PHASE_BITS      = nco_cfs_pkg::PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = nco_cfs_pkg::TABLE_ADDR_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [nco_cfs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [nco_cfs_pkg::STEP_BITS-1:0]      cfg_data,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]          in_i,
  input  wire logic signed [SAMPLE_BITS-1:0]          in_q,
  input  wire logic                                   in_last,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed      [SAMPLE_BITS-1:0]          out_i,
  output logic signed      [SAMPLE_BITS-1:0]          out_q,
  output logic                                        out_last
);
  import nco_cfs_pkg::*;

  pipe_ctl_t                     ctl;
  logic                          accept;
  logic                          v_a;
  logic                          v_b;
  logic                          last_a;
  logic                          last_b;
  logic signed [SAMPLE_BITS-1:0] smp_i;
  logic signed [SAMPLE_BITS-1:0] smp_q;
  logic [TABLE_ADDR_BITS+1:0]    table_idx;
  logic [SAMPLE_BITS-2:0]        s_mag;
  logic [SAMPLE_BITS-2:0]        c_mag;
  logic                          s_neg;
  logic                          c_neg;

  assign cfg_ready = 1'b1;

  // A stage moves on when it is empty or when the stage after it moves on.
  assign ctl.adv_c = !out_valid || !out_stall;
  assign ctl.adv_b = !v_b || ctl.adv_c;
  assign ctl.adv_a = !v_a || ctl.adv_b;
  assign in_stall  = !ctl.adv_a;
  assign accept    = in_valid && ctl.adv_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a       <= 1'b0;
      v_b       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.adv_a) begin
        v_a <= accept;
      end
      if (ctl.adv_b) begin
        v_b <= v_a;
      end
      if (ctl.adv_c) begin
        out_valid <= v_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv_a) begin
      smp_i  <= in_i;
      smp_q  <= in_q;
      last_a <= in_last;
    end
    if (ctl.adv_b) begin
      last_b <= last_a;
    end
    if (ctl.adv_c) begin
      out_last <= last_b;
    end
  end

  nco_cfs_phase #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_phase (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .last      (in_last),
    .table_idx (table_idx)
  );

  nco_cfs_sine_rom #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_sine_rom (
    .clk       (clk),
    .ctl       (ctl),
    .table_idx (table_idx),
    .s_mag     (s_mag),
    .c_mag     (c_mag),
    .s_neg     (s_neg),
    .c_neg     (c_neg)
  );

  nco_cfs_mixer #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mixer (
    .clk   (clk),
    .ctl   (ctl),
    .smp_i (smp_i),
    .smp_q (smp_q),
    .s_mag (s_mag),
    .c_mag (c_mag),
    .s_neg (s_neg),
    .c_neg (c_neg),
    .out_i (out_i),
    .out_q (out_q)
  );

`ifndef SYNTH
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v_a && v_b && out_valid && out_stall))
    else $error("input stalled while the pipeline has room");

  a_accept_fills_first: assert property (@(posedge clk) disable iff (rst)
    accept |=> v_a)
    else $error("accepted word did not enter the first stage");

  a_word_reaches_output: assert property (@(posedge clk) disable iff (rst)
    (v_b && ctl.adv_c) |=> out_valid)
    else $error("word in the product stage was lost");
`endif

endmodule

`default_nettype wire
